// ===== design/ils_pkg.sv =====
// Shared definitions for the indexed list store: field widths, mode and
// status codes, and default sizes. No dependencies.
package ils_pkg;

  // Port field widths
  localparam int MODE_W     = 3;
  localparam int POS_W      = 7;
  localparam int WORD_IN_W  = 32;
  localparam int WORD_OUT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int LENGTH_W   = 7;

  // Default sizes
  localparam int DEF_DEPTH      = 64;
  localparam int DEF_WORD_WIDTH = 32;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_GET     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== design/indexed_list_store.sv =====
// Indexed list store top level: list memory, move/swap sequencer and result
// register. Depends on ils_pkg.
//
// Usage: the input channel (in_valid / in_stall) carries one operation per
// transfer: get, insert, delete, update, reverse or clear, with a position
// and a data word. The result channel (out_valid / out_stall) returns exactly
// one result per operation: the word read, deleted or replaced, a status
// (ok, index out of range, store full) and the list length afterward.
// The list sits in a single-port-write, single-port-read memory with a
// registered read. Each memory move is a read (S_MVRD) then a write
// (S_MVWR); every entry shift and swap goes through that one port pair.
// in_stall is high while an operation runs. A finished result waits in the
// output register while out_stall is high; the next operation is taken
// meanwhile but cannot finish until that result is transferred.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. Stored words are not cleared; an empty list never reads them.
module indexed_list_store #(
  parameter int DEPTH      = ils_pkg::DEF_DEPTH,
  parameter int WORD_WIDTH = ils_pkg::DEF_WORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ils_pkg::MODE_W-1:0]      in_mode,
  input  logic [ils_pkg::POS_W-1:0]       in_position,
  input  logic [ils_pkg::WORD_IN_W-1:0]   in_word_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ils_pkg::WORD_OUT_W-1:0]  out_word_out,
  output logic [ils_pkg::STATUS_W-1:0]    out_status,
  output logic [ils_pkg::LENGTH_W-1:0]    out_length
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_RDAT  = 8'b0000_0100,
    S_MVRD  = 8'b0000_1000,
    S_MVWR  = 8'b0001_0000,
    S_WRW   = 8'b0010_0000,
    S_SWRD  = 8'b0100_0000,
    S_SWAP  = 8'b1000_0000
  } state_t;

  // Sequencer state, and the phase bit used in S_WRW, S_SWRD and S_SWAP
  state_t                        state_r, state_nxt;
  logic                          ph_r, ph_nxt;
  logic [ils_pkg::MODE_W-1:0]    op_r, op_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic [AW-1:0]                 lo_r, lo_nxt;
  logic [AW-1:0]                 hi_r, hi_nxt;
  logic [AW-1:0]                 last_r, last_nxt;
  logic [WORD_WIDTH-1:0]         word_r, word_nxt;
  logic [WORD_WIDTH-1:0]         hold_r, hold_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [ils_pkg::WORD_OUT_W-1:0] res_word_r, res_word_nxt;
  logic [ils_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [ils_pkg::WORD_OUT_W-1:0] out_word_r, out_word_nxt;
  logic [ils_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [ils_pkg::LENGTH_W-1:0]  out_length_r, out_length_nxt;

  logic [WORD_WIDTH-1:0]         mem [DEPTH];
  logic [WORD_WIDTH-1:0]         rd_data_r;
  logic [AW-1:0]                 rd_addr;
  logic                          mem_we;
  logic [AW-1:0]                 wr_addr;
  logic [WORD_WIDTH-1:0]         wr_data;

  logic                          in_xfer;
  logic                          out_free;
  logic [CMPW-1:0]               pos_c;
  logic [CMPW-1:0]               cnt_c;
  logic [AW:0]                   lo_plus2;

  assign in_stall     = (state_r != S_IDLE);
  assign in_xfer      = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_word_out = out_word_r;
  assign out_status   = out_status_r;
  assign out_length   = out_length_r;

  assign pos_c    = CMPW'(in_position);
  assign cnt_c    = CMPW'(cnt_r);
  assign lo_plus2 = {1'b0, lo_r} + (AW+1)'(2);

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Select read address by sequencer step
  always_comb begin
    rd_addr = lo_r;
    if (state_r == S_MVRD || (state_r == S_SWRD && ph_r)) begin
      rd_addr = hi_r;
    end
  end

  // Select write port by sequencer step
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = lo_r;
    wr_data = rd_data_r;
    unique case (state_r)
      S_RDAT: begin
        mem_we  = (op_r == ils_pkg::MODE_UPDATE);
        wr_data = word_r;
      end
      S_MVWR: begin
        mem_we = 1'b1;
      end
      // Write the inserted word in phase 0 only; phase 1 hands off the result
      S_WRW: begin
        mem_we  = !ph_r;
        wr_addr = pos_r;
        wr_data = word_r;
      end
      S_SWAP: begin
        mem_we = 1'b1;
        if (ph_r) begin
          wr_addr = hi_r;
          wr_data = hold_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer and result path
  always_comb begin
    state_nxt      = state_r;
    ph_nxt         = ph_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    last_nxt       = last_r;
    word_nxt       = word_r;
    hold_nxt       = hold_r;
    cnt_nxt        = cnt_r;
    res_word_nxt   = res_word_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_length_nxt = out_length_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_mode;
          pos_nxt        = AW'(in_position);
          word_nxt       = WORD_WIDTH'(in_word_in);
          lo_nxt         = AW'(in_position);
          last_nxt       = AW'(cnt_r - CW'(1));
          res_word_nxt   = '0;
          res_status_nxt = ils_pkg::ST_OK;
          state_nxt      = S_WRW;
          // decode operation
          unique case (in_mode)
            ils_pkg::MODE_GET, ils_pkg::MODE_UPDATE: begin
              if (pos_c >= cnt_c) begin
                res_status_nxt = ils_pkg::ST_RANGE;
                state_nxt      = S_IDLE;
              end else begin
                state_nxt = S_RD;
              end
            end
            ils_pkg::MODE_DELETE: begin
              if (pos_c >= cnt_c) begin
                res_status_nxt = ils_pkg::ST_RANGE;
                state_nxt      = S_IDLE;
              end else begin
                cnt_nxt   = cnt_r - CW'(1);
                state_nxt = S_RD;
              end
            end
            ils_pkg::MODE_INSERT: begin
              if (pos_c > cnt_c) begin
                res_status_nxt = ils_pkg::ST_RANGE;
                state_nxt      = S_IDLE;
              end else if (cnt_r == CW'(DEPTH)) begin
                res_status_nxt = ils_pkg::ST_FULL;
                state_nxt      = S_IDLE;
              end else begin
                cnt_nxt = cnt_r + CW'(1);
                if (pos_c == cnt_c) begin
                  state_nxt = S_WRW;
                end else begin
                  lo_nxt    = AW'(cnt_r);
                  hi_nxt    = AW'(cnt_r - CW'(1));
                  state_nxt = S_MVRD;
                end
              end
            end
            ils_pkg::MODE_REVERSE: begin
              if (cnt_r > CW'(1)) begin
                lo_nxt    = '0;
                hi_nxt    = AW'(cnt_r - CW'(1));
                ph_nxt    = 1'b0;
                state_nxt = S_SWRD;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            ils_pkg::MODE_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_IDLE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
          // operations that finish at once go straight to the result stage
          if (state_nxt == S_IDLE) begin
            state_nxt = S_WRW;
            ph_nxt    = 1'b1;
          end else begin
            ph_nxt = 1'b0;
          end
        end
      end

      // Issue read of the target entry
      S_RD: begin
        state_nxt = S_RDAT;
      end

      // Capture the target word, write the update word, start delete shifting
      S_RDAT: begin
        res_word_nxt = ils_pkg::WORD_OUT_W'(rd_data_r);
        ph_nxt       = 1'b1;
        state_nxt    = S_WRW;
        if (op_r == ils_pkg::MODE_DELETE && lo_r != last_r) begin
          hi_nxt    = lo_r + AW'(1);
          ph_nxt    = 1'b0;
          state_nxt = S_MVRD;
        end
      end

      // Issue read of the move source
      S_MVRD: begin
        state_nxt = S_MVWR;
      end

      // Write moved word, advance pointers
      S_MVWR: begin
        state_nxt = S_MVRD;
        if (op_r == ils_pkg::MODE_DELETE) begin
          if (hi_r == last_r) begin
            ph_nxt    = 1'b1;
            state_nxt = S_WRW;
          end else begin
            lo_nxt = lo_r + AW'(1);
            hi_nxt = hi_r + AW'(1);
          end
        end else begin
          if (hi_r == pos_r) begin
            ph_nxt    = 1'b0;
            state_nxt = S_WRW;
          end else begin
            lo_nxt = lo_r - AW'(1);
            hi_nxt = hi_r - AW'(1);
          end
        end
      end

      // Phase 0: write the inserted word. Phase 1: hand result to output
      S_WRW: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = res_word_r;
          out_status_nxt = res_status_r;
          out_length_nxt = ils_pkg::LENGTH_W'(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      // Phase 0: read low entry. Phase 1: read high entry, hold low word
      S_SWRD: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          hold_nxt  = rd_data_r;
          ph_nxt    = 1'b0;
          state_nxt = S_SWAP;
        end
      end

      // Phase 0: write high word low. Phase 1: write held word high, step
      S_SWAP: begin
        ph_nxt = 1'b1;
        if (ph_r) begin
          lo_nxt = lo_r + AW'(1);
          hi_nxt = hi_r - AW'(1);
          if (lo_plus2 < {1'b0, hi_r}) begin
            ph_nxt    = 1'b0;
            state_nxt = S_SWRD;
          end else begin
            ph_nxt    = 1'b1;
            state_nxt = S_WRW;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    last_r       <= last_nxt;
    word_r       <= word_nxt;
    hold_r       <= hold_nxt;
    res_word_r   <= res_word_nxt;
    res_status_r <= res_status_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_length_r <= out_length_nxt;
  end

`ifndef SYNTH
  // Length never exceeds the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("list length exceeds depth");

  // A full-store result is only produced with the store full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRW && ph_r && res_status_r == ils_pkg::ST_FULL) |->
    (cnt_r == CW'(DEPTH)))
    else $error("full status with room left");

  // One operation moves the length by at most one, or clears it
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (cnt_r == $past(cnt_r)) || (cnt_r == CW'($past(cnt_r) + CW'(1)))
    || (cnt_r == CW'($past(cnt_r) - CW'(1))) || (cnt_r == '0))
    else $error("length jumped by more than one");

  // Swap pointers stay ordered while reversing
  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWRD) |-> (lo_r < hi_r))
    else $error("reverse pointers crossed");

  // A pending result is never overwritten before its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_word_r)
    && $stable(out_status_r) && $stable(out_length_r)))
    else $error("pending result overwritten");
`endif

endmodule

// ===== bench/tb_indexed_list_store.sv =====
// Testbench for indexed_list_store: directed and random list operations, with
// a built-in list predictor and a result checker. Depends on ils_pkg and the
// indexed_list_store RTL.
module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int LIST_DEPTH     = DEF_DEPTH;
  localparam int TIMEOUT_CYCLES = 1_200_000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int REPORT_LIMIT   = 10;

  // Modes the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  // Bias of a random phase
  typedef enum int {BIAS_GROW, BIAS_SHRINK, BIAS_CHURN} op_bias_t;

  typedef struct packed {
    logic [WORD_OUT_W-1:0] word;
    logic [STATUS_W-1:0]   status;
    logic [LENGTH_W-1:0]   length;
  } list_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode;
  logic [POS_W-1:0]      in_position;
  logic [WORD_IN_W-1:0]  in_word_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [WORD_OUT_W-1:0] out_word_out;
  logic [STATUS_W-1:0]   out_status;
  logic [LENGTH_W-1:0]   out_length;

  // Predicted list contents and pending results
  logic [WORD_IN_W-1:0] list_words [LIST_DEPTH];
  int                   list_len;
  list_result_t         pending_results [$];

  int error_count;
  int ops_sent;
  int results_checked;
  int range_seen;
  int full_seen;

  // Idling controls for both sides
  bit send_idle_on;
  int send_idle_pct;
  bit recv_idle_on;
  int recv_idle_pct;
  int pause_request;
  int burst_left;

  indexed_list_store DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word_out (out_word_out),
    .out_status   (out_status),
    .out_length   (out_length)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = ~clk;
  end

  // Apply one operation to the predicted list and queue its result
  function automatic void predict_list_op(input logic [MODE_W-1:0] mode,
                                          input logic [POS_W-1:0] pos,
                                          input logic [WORD_IN_W-1:0] word);
    list_result_t res;
    int n;
    int p;
    int lo;
    int hi;
    logic [WORD_IN_W-1:0] tmp;
    res = '0;
    n = list_len;
    p = pos;
    case (mode)
      MODE_GET, MODE_DELETE, MODE_UPDATE: begin
        if (p >= n) begin
          res.status = ST_RANGE;
        end else begin
          res.word = list_words[p];
          if (mode == MODE_DELETE) begin
            for (int k = p; k + 1 < n; k++) list_words[k] = list_words[k + 1];
            list_len = n - 1;
          end else if (mode == MODE_UPDATE) begin
            list_words[p] = word;
          end
        end
      end
      MODE_INSERT: begin
        if (p > n) begin
          res.status = ST_RANGE;
        end else if (n >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int k = n; k > p; k--) list_words[k] = list_words[k - 1];
          list_words[p] = word;
          list_len = n + 1;
        end
      end
      MODE_REVERSE: begin
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
          tmp = list_words[lo];
          list_words[lo] = list_words[hi];
          list_words[hi] = tmp;
          lo++;
          hi--;
        end
      end
      MODE_CLEAR: begin
        list_len = 0;
      end
      default: ;
    endcase
    res.length = LENGTH_W'(list_len);
    pending_results.push_back(res);
  endfunction

  // Offer one operation and hold it until the block takes the transfer
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                         input logic [WORD_IN_W-1:0] word);
    int gap;
    gap = 0;
    if (send_idle_on && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    in_word_in  <= word;
    do @(posedge clk); while (in_stall);
    predict_list_op(mode, pos, word);
    ops_sent++;
  endtask

  // Drop the offered transfer, then wait for every result to come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus a long hold when one is requested
  always @(negedge clk) begin
    if (pause_request > 0) begin
      burst_left = pause_request;
      pause_request = 0;
    end else if (burst_left == 0 && recv_idle_on && $urandom_range(0, 99) < recv_idle_pct) begin
      burst_left = $urandom_range(1, 16);
    end
    out_stall <= (burst_left > 0);
    if (burst_left > 0) burst_left--;
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: word %h status %0d length %0d",
                   out_word_out, out_status, out_length);
      end else begin
        want = pending_results.pop_front();
        if (out_word_out !== want.word || out_status !== want.status ||
            out_length !== want.length) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display({"mismatch on result %0d: word exp %h got %h, ",
                      "status exp %0d got %0d, length exp %0d got %0d"},
                     results_checked, want.word, out_word_out, want.status, out_status,
                     want.length, out_length);
        end
        if (want.status == ST_RANGE) range_seen++;
        if (want.status == ST_FULL) full_seen++;
        results_checked++;
      end
    end
  end

  function automatic logic [WORD_IN_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return WORD_IN_W'($urandom);
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input op_bias_t bias);
    int roll;
    int ins_cut;
    int del_cut;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_GROW:   begin ins_cut = 55; del_cut = 65; end
      BIAS_SHRINK: begin ins_cut = 10; del_cut = 60; end
      default:     begin ins_cut = 30; del_cut = 60; end
    endcase
    if (roll < ins_cut) return MODE_INSERT;
    if (roll < del_cut) return MODE_DELETE;
    if (roll < 76) return MODE_GET;
    if (roll < 90) return MODE_UPDATE;
    if (roll < 96) return MODE_REVERSE;
    if (roll < 98) return MODE_CLEAR;
    return (roll == 98) ? MODE_SPARE_LO : MODE_SPARE_HI;
  endfunction

  // Mostly in-range positions, with the ends favored and some out of range
  function automatic logic [POS_W-1:0] pick_position(input logic [MODE_W-1:0] mode);
    int top;
    int roll;
    top = (mode == MODE_INSERT) ? list_len : list_len - 1;
    roll = $urandom_range(0, 99);
    if (roll < 12) return POS_W'($urandom_range(top + 1, 127));
    if (top < 0) return '0;
    if (roll < 20) return '0;
    if (roll < 28) return POS_W'(top);
    return POS_W'($urandom_range(0, top));
  endfunction

  task automatic run_random_ops(input int count, input op_bias_t bias);
    logic [MODE_W-1:0] mode;
    for (int i = 0; i < count; i++) begin
      mode = pick_mode(bias);
      send_op(mode, pick_position(mode), pick_word());
    end
  endtask

  // Boundary indexes, every mode, short reverses and ignored modes
  task automatic test_directed();
    send_op(MODE_GET, 0, 32'h0000_0001);
    send_op(MODE_DELETE, 0, '0);
    send_op(MODE_UPDATE, 0, '1);
    send_op(MODE_REVERSE, 0, '0);
    send_op(MODE_INSERT, 1, 32'h1111_1111);
    send_op(MODE_INSERT, 0, '0);
    send_op(MODE_REVERSE, 0, '0);
    send_op(MODE_INSERT, 1, '1);
    send_op(MODE_INSERT, 1, 32'hA5A5_A5A5);
    send_op(MODE_INSERT, 3, 32'h5A5A_5A5A);
    send_op(MODE_INSERT, 5, 32'h7FFF_FFFF);
    send_op(MODE_GET, 4, '0);
    send_op(MODE_REVERSE, 0, '0);
    send_op(MODE_GET, 0, '0);
    send_op(MODE_GET, 3, '0);
    send_op(MODE_UPDATE, 2, 32'h1234_5678);
    send_op(MODE_DELETE, 0, '0);
    send_op(MODE_DELETE, 2, '0);
    send_op(MODE_GET, 127, '1);
    send_op(MODE_INSERT, 0, 32'hDEAD_BEEF);
    send_op(MODE_REVERSE, 0, '0);
    send_op(MODE_SPARE_LO, 0, '0);
    send_op(MODE_SPARE_HI, 127, '1);
    send_op(MODE_CLEAR, 0, '0);
    send_op(MODE_GET, 0, '0);
  endtask

  // Fill to capacity, poke the full store, then empty it again
  task automatic test_fill_and_drain();
    send_op(MODE_CLEAR, 0, '0);
    while (list_len < LIST_DEPTH)
      send_op(MODE_INSERT, POS_W'($urandom_range(0, list_len)), pick_word());
    send_op(MODE_INSERT, POS_W'($urandom_range(0, LIST_DEPTH - 1)), pick_word());
    send_op(MODE_INSERT, POS_W'(LIST_DEPTH), pick_word());
    send_op(MODE_INSERT, POS_W'(LIST_DEPTH + 1), pick_word());
    send_op(MODE_GET, POS_W'(LIST_DEPTH - 1), '0);
    send_op(MODE_GET, POS_W'(LIST_DEPTH), '0);
    send_op(MODE_UPDATE, 0, pick_word());
    send_op(MODE_REVERSE, 0, '0);
    send_op(MODE_GET, 0, '0);
    send_op(MODE_UPDATE, POS_W'(LIST_DEPTH - 1), pick_word());
    while (list_len > 0)
      send_op(MODE_DELETE, POS_W'($urandom_range(0, list_len - 1)), '0);
    send_op(MODE_DELETE, 0, '0);
  endtask

  // Hold the result side for a long stretch while operations keep coming
  task automatic test_backpressure();
    logic [MODE_W-1:0] mode;
    bit prev_idle;
    prev_idle = send_idle_on;
    send_idle_on = 1'b0;
    pause_request = 300;
    for (int i = 0; i < 16; i++) begin
      mode = (i % 3 == 2) ? MODE_GET : MODE_INSERT;
      send_op(mode, pick_position(mode), pick_word());
    end
    wait_drained();
    send_idle_on = prev_idle;
  endtask

  // Random phases with shifting bias and idling density
  task automatic test_random_mix();
    int pct_choice [4];
    pct_choice = '{0, 10, 30, 60};
    for (int ph = 0; ph < 25; ph++) begin
      send_idle_pct = pct_choice[$urandom_range(0, 3)];
      recv_idle_pct = pct_choice[$urandom_range(0, 3)];
      run_random_ops(50, op_bias_t'(ph % 3));
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_quiet_tail();
    wait_drained();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    run_random_ops(75, BIAS_GROW);
    run_random_ops(75, BIAS_CHURN);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_GET;
    in_position   = '0;
    in_word_in    = '0;
    out_stall     = 1'b0;
    list_len      = 0;
    error_count   = 0;
    ops_sent      = 0;
    results_checked = 0;
    range_seen    = 0;
    full_seen     = 0;
    pause_request = 0;
    burst_left    = 0;
    send_idle_on  = 1'b1;
    send_idle_pct = 30;
    recv_idle_on  = 1'b1;
    recv_idle_pct = 20;
    for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();
    test_quiet_tail();

    // Drop valid, drain, then watch for stray results
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d list operations (get/insert/delete/update/reverse/clear, spare modes)",
             ops_sent);
    $display("Checked %0d results: %0d index errors, %0d full-store rejects",
             results_checked, range_seen, full_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ils_pkg.sv
design/indexed_list_store.sv
bench/tb_indexed_list_store.sv
